/* hdl/rotenc_pkg.sv */
// Shared constants, types and the quadrature transition table of the rotary encoder core.
package rotenc_pkg;

   // Configuration register indexes
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_LONG_PRESS = 1'b1;

   // Configuration reset values
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd600;

   // Both pins idle high after reset
   localparam logic [1:0] AB_IDLE = 2'b11;

   // Tick count limits
   localparam int TICK_LIMIT = 32767;

   // Quadrature ticks per mechanical detent, range 1 to 4
   localparam int TICKS_PER_DETENT = 4;

   // Fraction bits of the reciprocal used to divide a 15-bit magnitude by the detent size
   localparam int DIV_SHIFT = 17;

   // Transition step: index is {previous AB, current AB}; +1, -1 or 0 for a skipped step
   typedef logic signed [1:0] step_type;

   function automatic step_type step_value(input logic [3:0] idx);
      step_type s;
      begin
         unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
         endcase
         return s;
      end
   endfunction

endpackage

/* hdl/rotary_encoder_with_push_switch_core.sv */
// Rotary encoder quadrature decoder and push switch debouncer, top level.
//
// One poll transaction goes in per clock cycle and one result transaction comes out per
// poll. A poll is taken into an input register and then processed by single-pass
// logic that updates the decoder and switch state and loads the result register, so
// rsp_tvalid rises once the poll has passed both registers; the block sustains one poll
// per cycle unless stalled. The input side only stalls while a result waits with
// rsp_tready low and the input register is occupied. Time differences are taken modulo
// 2^32; the switch level must be stable for strictly longer than the debounce time
// (register 0) before it is accepted. On a collect poll the whole detents (truncated
// toward zero) are returned and removed from the count, and the short- and long-press
// flags are reported and cleared.
module rotary_encoder_with_push_switch_core #(
   parameter int TICKS_PER_DETENT = rotenc_pkg::TICKS_PER_DETENT
) (
   input  logic        clock,
   input  logic        reset,
   // Poll channel; req_tdata: pin_a[0], pin_b[1], switch_pin[2], now_ms[34:3],
   // collect[35], zero[39:36]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Result channel; rsp_tdata: detents[15:0], short_press[16], long_press[17],
   // held[18], zero[23:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // Configuration write port
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import rotenc_pkg::*;

   // Reciprocal of the detent size, exact for 15-bit magnitudes
   localparam int DETENT_RECIP = ((2 ** DIV_SHIFT) + TICKS_PER_DETENT - 1) / TICKS_PER_DETENT;

   // Configuration
   logic [15:0] settle_ms_ff;
   logic [15:0] long_press_ms_ff;

   // Input stage
   logic        s1_valid_ff;
   logic        s1_pin_a_ff;
   logic        s1_pin_b_ff;
   logic        s1_switch_ff;
   logic [31:0] s1_now_ff;
   logic        s1_collect_ff;

   // Decoder and switch state
   logic [1:0]         last_ab_ff,     last_ab_in;
   logic signed [15:0] tick_ff,        tick_in;
   logic               raw_last_ff,    raw_last_in;
   logic [31:0]        deb_start_ff,   deb_start_in;
   logic               stable_ff,      stable_in;
   logic [31:0]        press_start_ff, press_start_in;
   logic               long_done_ff,   long_done_in;
   logic               short_flag_ff,  short_flag_in;
   logic               long_flag_ff,   long_flag_in;

   // Result register
   logic               rsp_valid_ff;
   logic signed [15:0] detents_ff,     detents_in;
   logic               short_out_ff,   short_out_in;
   logic               long_out_ff,    long_out_in;
   logic               held_ff;

   // Handshake
   logic out_free;
   logic advance;
   logic req_fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, held_ff, long_out_ff, short_out_ff, detents_ff};

   // Quadrature decode with saturating tick count
   logic [1:0]         ab;
   logic signed [16:0] tick_sum;
   logic signed [15:0] tick_sat;

   always_comb begin
      ab       = {s1_pin_a_ff, s1_pin_b_ff};
      tick_sum = 17'(tick_ff);
      if (ab != last_ab_ff) begin
         tick_sum = 17'(tick_ff) + 17'(step_value({last_ab_ff, ab}));
      end
      if (tick_sum > 17'sd32767) begin
         tick_sat = 16'(TICK_LIMIT);
      end else if (tick_sum < -17'sd32767) begin
         tick_sat = -16'(TICK_LIMIT);
      end else begin
         tick_sat = tick_sum[15:0];
      end
      last_ab_in = ab;
   end

   // Switch debounce, short-press and long-press detection
   logic        raw;
   logic [31:0] deb_diff;
   logic [31:0] press_diff;
   logic        short_pend;
   logic        long_pend;

   always_comb begin
      raw            = !s1_switch_ff;
      deb_start_in   = deb_start_ff;
      raw_last_in    = raw_last_ff;
      stable_in      = stable_ff;
      press_start_in = press_start_ff;
      long_done_in   = long_done_ff;
      short_pend     = short_flag_ff;
      long_pend      = long_flag_ff;
      if (raw != raw_last_ff) begin
         deb_start_in = s1_now_ff;
         raw_last_in  = raw;
      end
      deb_diff = s1_now_ff - deb_start_in;
      if (deb_diff > {16'd0, settle_ms_ff}) begin
         if (raw && !stable_ff) begin
            stable_in      = 1'b1;
            press_start_in = s1_now_ff;
            long_done_in   = 1'b0;
         end else if (!raw && stable_ff) begin
            stable_in = 1'b0;
            if (!long_done_ff) begin
               short_pend = 1'b1;
            end
         end
      end
      press_diff = s1_now_ff - press_start_in;
      if (stable_in && !long_done_in && (press_diff >= {16'd0, long_press_ms_ff})) begin
         long_done_in = 1'b1;
         long_pend    = 1'b1;
      end
   end

   // Detent extraction: on a collect poll, divide magnitude by the detent size, keep the signed remainder
   logic        tick_neg;
   logic [14:0] mag;
   logic [32:0] quot_prod;
   logic [14:0] quot;
   logic [17:0] quot_ticks;
   logic [14:0] rem;

   always_comb begin
      tick_neg   = tick_sat[15];
      mag        = tick_neg ? 15'(-tick_sat) : tick_sat[14:0];
      quot_prod  = 33'(mag) * 33'(DETENT_RECIP);
      quot       = quot_prod[DIV_SHIFT +: 15];
      quot_ticks = 18'(quot) * 18'(TICKS_PER_DETENT);
      rem        = mag - quot_ticks[14:0];
      detents_in    = 16'sd0;
      short_out_in  = 1'b0;
      long_out_in   = 1'b0;
      tick_in       = tick_sat;
      short_flag_in = short_pend;
      long_flag_in  = long_pend;
      if (s1_collect_ff) begin
         detents_in    = tick_neg ? -16'({1'b0, quot}) : 16'({1'b0, quot});
         tick_in       = tick_neg ? -16'({1'b0, rem}) : 16'({1'b0, rem});
         short_out_in  = short_pend;
         long_out_in   = long_pend;
         short_flag_in = 1'b0;
         long_flag_in  = 1'b0;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ms_ff     <= DEBOUNCE_RESET;
         long_press_ms_ff <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DEBOUNCE:   settle_ms_ff     <= csr_wdata;
            REG_LONG_PRESS: long_press_ms_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: hold while the result side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pin_a_ff   <= req_tdata[0];
         s1_pin_b_ff   <= req_tdata[1];
         s1_switch_ff  <= req_tdata[2];
         s1_now_ff     <= req_tdata[34:3];
         s1_collect_ff <= req_tdata[35];
      end
   end

   // State update: advance once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ab_ff     <= AB_IDLE;
         tick_ff        <= 16'sd0;
         raw_last_ff    <= 1'b0;
         deb_start_ff   <= 32'd0;
         stable_ff      <= 1'b0;
         press_start_ff <= 32'd0;
         long_done_ff   <= 1'b0;
         short_flag_ff  <= 1'b0;
         long_flag_ff   <= 1'b0;
      end else if (advance) begin
         last_ab_ff     <= last_ab_in;
         tick_ff        <= tick_in;
         raw_last_ff    <= raw_last_in;
         deb_start_ff   <= deb_start_in;
         stable_ff      <= stable_in;
         press_start_ff <= press_start_in;
         long_done_ff   <= long_done_in;
         short_flag_ff  <= short_flag_in;
         long_flag_ff   <= long_flag_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         detents_ff   <= detents_in;
         short_out_ff <= short_out_in;
         long_out_ff  <= long_out_in;
         held_ff      <= stable_in;
      end
   end

endmodule
